// File: rtl/core/sensor_reply_deframer_unit_macros.svh
// Assertion helpers for the sensor reply deframer.
// Each expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef SENSOR_REPLY_DEFRAMER_UNIT_MACROS_SVH
`define SENSOR_REPLY_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srd_pkg.sv
package srd_pkg;

  // Payload limit default.
  localparam int MAX_PAYLOAD_DFLT = 16;

  // Port field widths.
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int POS_W       = 4;
  localparam int PLEN_W      = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Frame layout.
  localparam int HEADER_BYTES = 9;
  localparam int TYPE_POS     = 7;
  localparam int LEN_HI_POS   = 8;
  localparam int START2_POS   = 2;
  localparam int CSUM_BYTES   = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] START_CODE_RST = 16'hEF01;
  localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CODE = 1'b0,
    CFG_TIMEOUT    = 1'b1
  } srd_cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_UNUSED = 2'd3
  } srd_cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_LONG    = 3'd4
  } srd_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HUNT  = 2'd1,
    PH_FRAME = 2'd2
  } srd_phase_t;

  typedef struct packed {
    logic [PLEN_W-1:0] payload_length;
    logic [POS_W-1:0]  byte_pos;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] packet_type;
  } srd_fields_t;

  typedef struct packed {
    srd_kind_t   kind;
    srd_fields_t fields;
  } srd_result_t;

endpackage

// File: rtl/core/sensor_reply_deframer_unit.sv
// Channel   | Dir | Transfer contents
// ----------+-----+-----------------------------------------------------------
// in_       | in  | tuser = cmd, tdata = rx_byte
// out_      | out | tuser = kind, tdata = type, data, position, payload length
// cfg_      | in  | write enable, register index, 16-bit write data
//
// Each input transfer is decoded in one cycle; a new transfer may be taken every cycle.
// A result is registered into the output register, or into the skid register while the output register is stalled.
// A two-entry output stage (output register plus skid register) keeps input
// flowing while the consumer stalls; in_tready drops only when both hold a result.
// rst_n is synchronous, active low; it restores register defaults and idles the parser.
`include "sensor_reply_deframer_unit_macros.svh"

module sensor_reply_deframer_unit #(
  parameter int MAX_PAYLOAD = srd_pkg::MAX_PAYLOAD_DFLT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [srd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srd_pkg::CFG_W-1:0]        cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [srd_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] rx_byte
  input  logic [srd_pkg::CMD_W-1:0]        in_tuser,   // [1:0] cmd
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] packet_type, [15:8] data_byte, [19:16] byte_pos,
  // [24:20] payload_length, [31:25] zero
  output logic [srd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [srd_pkg::KIND_W-1:0]       out_tuser   // [2:0] kind
);

  import srd_pkg::*;

  // Byte counter covers header, payload and both checksum bytes.
  localparam int CNT_W  = $clog2(MAX_PAYLOAD + HEADER_BYTES + CSUM_BYTES + 1);
  localparam int PAY_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_W  = 2 * BYTE_W;
  localparam int FLD_W  = $bits(srd_fields_t);

  localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_START2 = CNT_W'(START2_POS);
  localparam logic [CNT_W-1:0] CNT_TYPE   = CNT_W'(TYPE_POS);
  localparam logic [CNT_W-1:0] CNT_LENHI  = CNT_W'(LEN_HI_POS);
  localparam logic [CNT_W-1:0] CNT_HDR    = CNT_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CNT_PAY0   = CNT_W'(HEADER_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(CSUM_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_PAYLOAD + CSUM_BYTES);
  localparam logic [CFG_W-1:0] TICK_SAT   = '1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] start_code_r;
  logic [CFG_W-1:0] timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (srd_cfg_idx_t'(cfg_index))
        CFG_START_CODE: start_code_r <= cfg_wdata;
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  srd_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [CFG_W-1:0]  ticks_r, ticks_nxt;
  logic              start2_ok_r, start2_ok_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [PAY_W-1:0]  pay_r, pay_nxt;

  logic              in_acc;
  srd_cmd_t          cmd;
  logic [BYTE_W-1:0] rx_byte;
  logic [CNT_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  full_len;
  logic [CNT_W-1:0]  pay_cnt;
  logic [CFG_W-1:0]  ticks_inc;

  logic              res_vld;
  srd_result_t       res;

  assign in_acc  = in_tvalid && in_tready;
  assign cmd     = srd_cmd_t'(in_tuser);
  assign rx_byte = in_tdata[BYTE_W-1:0];
  assign cnt_inc = byte_cnt_r + CNT_ONE;
  assign full_len = {len_hi_r, rx_byte};
  assign pay_cnt  = CNT_W'(pay_r);
  assign ticks_inc = (ticks_r == TICK_SAT) ? ticks_r : ticks_r + CFG_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    ticks_nxt     = ticks_r;
    start2_ok_nxt = start2_ok_r;
    type_nxt      = type_r;
    len_hi_nxt    = len_hi_r;
    pay_nxt       = pay_r;
    res_vld       = 1'b0;
    res.kind      = KIND_DATA;
    res.fields    = '0;

    if (in_acc) begin
      case (cmd)
        CMD_BEGIN: begin
          // arm: clear counters and held header fields
          phase_nxt     = PH_HUNT;
          byte_cnt_nxt  = '0;
          ticks_nxt     = '0;
          start2_ok_nxt = 1'b0;
          type_nxt      = '0;
          len_hi_nxt    = '0;
          pay_nxt       = '0;
        end
        CMD_TICK: begin
          if (phase_r != PH_IDLE) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= timeout_r) begin
              phase_nxt = PH_IDLE;
              res_vld   = 1'b1;
              res.kind  = KIND_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          case (phase_r)
            PH_HUNT: begin
              // drop bytes until the first start byte shows up
              if (rx_byte == start_code_r[CFG_W-1:BYTE_W]) begin
                phase_nxt    = PH_FRAME;
                byte_cnt_nxt = CNT_ONE;
              end
            end
            PH_FRAME: begin
              byte_cnt_nxt = cnt_inc;
              if (cnt_inc == CNT_START2) begin
                start2_ok_nxt = (rx_byte == start_code_r[BYTE_W-1:0]);
              end else if (cnt_inc == CNT_TYPE) begin
                type_nxt = rx_byte;
              end else if (cnt_inc == CNT_LENHI) begin
                len_hi_nxt = rx_byte;
              end else if (cnt_inc == CNT_HDR) begin
                if (!start2_ok_r) begin
                  phase_nxt = PH_IDLE;
                  res_vld   = 1'b1;
                  res.kind  = KIND_BAD;
                end else if (full_len < LEN_MIN || full_len > LEN_MAX) begin
                  phase_nxt = PH_IDLE;
                  res_vld   = 1'b1;
                  res.kind  = KIND_LONG;
                end else begin
                  pay_nxt = PAY_W'(full_len - LEN_MIN);
                end
              end else if (cnt_inc > CNT_HDR) begin
                if (cnt_inc <= CNT_HDR + pay_cnt) begin
                  res_vld                = 1'b1;
                  res.kind               = KIND_DATA;
                  res.fields.data_byte   = rx_byte;
                  res.fields.byte_pos    = POS_W'(cnt_inc - CNT_PAY0);
                end else if (cnt_inc >= CNT_PAY0 + pay_cnt + CNT_ONE) begin
                  // last checksum byte closes the frame
                  phase_nxt                   = PH_IDLE;
                  res_vld                     = 1'b1;
                  res.kind                    = KIND_DONE;
                  res.fields.payload_length   = PLEN_W'(pay_r);
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    res.fields.packet_type = type_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r  <= '0;
      ticks_r     <= '0;
      start2_ok_r <= 1'b0;
      type_r      <= '0;
      len_hi_r    <= '0;
      pay_r       <= '0;
    end else begin
      byte_cnt_r  <= byte_cnt_nxt;
      ticks_r     <= ticks_nxt;
      start2_ok_r <= start2_ok_nxt;
      type_r      <= type_nxt;
      len_hi_r    <= len_hi_nxt;
      pay_r       <= pay_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  logic        out_vld_r;
  srd_result_t out_res_r;
  logic        skid_vld_r;
  srd_result_t skid_res_r;
  logic        out_pop;

  assign out_pop   = out_vld_r && out_tready;
  assign in_tready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      // input is held off; advance skid into the output register on a pop
      if (out_pop) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_pop) begin
      out_vld_r <= res_vld;
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_vld_r || out_pop) begin
      if (res_vld) begin
        out_res_r <= res;
      end
    end else if (res_vld) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {(OUT_TDATA_W - FLD_W)'(0), out_res_r.fields};

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SRD_ASSERT_IMP(a_skid_behind_out, skid_vld_r, out_vld_r, "skid holds a result while output register is empty")
  `SRD_ASSERT_NXT(a_terminal_idles, res_vld && res.kind != KIND_DATA, phase_r == PH_IDLE, "parser not idle after a terminal result")
  `SRD_ASSERT_NXT(a_begin_arms, in_acc && cmd == CMD_BEGIN, phase_r == PH_HUNT && ticks_r == '0 && byte_cnt_r == '0, "begin did not arm the parser")
  `SRD_ASSERT_IMP(a_cnt_bound, phase_r == PH_FRAME, byte_cnt_r <= CNT_PAY0 + pay_cnt, "byte counter ran past the frame end")

endmodule

// File: test/sensor_reply_deframer_unit_tb.sv
module sensor_reply_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srd_pkg::*;

  localparam int MAX_PAY     = MAX_PAYLOAD_DFLT;
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to let pass after the last result so a frame byte that causes
  // nothing has left the pipeline before a register changes.
  localparam int DRAIN_CYCLES = 8;

  // One queued transfer toward the block, with the idle gap that follows it.
  typedef struct {
    srd_cmd_t   cmd;
    logic [7:0] rx;
    int         gap;
    bit         drain;
  } link_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [CMD_W-1:0]       in_tuser = '0;   // [1:0] cmd

  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [7:0] type, [15:8] data, [19:16] pos, [24:20] length
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;       // [2:0] kind

  sensor_reply_deframer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the deframer: registers and parser state
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_code    = START_CODE_RST;
  logic [15:0] shadow_timeout = TIMEOUT_RST;

  srd_phase_t  rx_phase    = PH_IDLE;
  logic [4:0]  frame_bytes = '0;
  logic [15:0] idle_ticks  = '0;
  bit          start2_ok   = 1'b0;
  logic [7:0]  held_ptype  = '0;
  logic [15:0] length_word = '0;

  srd_result_t replies_due[$];   // expected results, oldest first
  link_item_t  link_queue[$];    // transfers waiting for the driver

  int items_unaccepted = 0;
  int stim_count       = 0;
  int in_transfers     = 0;
  int settings_used    = 1;
  int mismatches       = 0;
  int cycle_count      = 0;
  int kind_seen[8];
  bit frame_calm       = 1'b0;
  bit drain_next       = 1'b0;

  function automatic void expect_reply(srd_kind_t kind, logic [7:0] data, int pos, int plen);
    srd_result_t r;
    r.kind                  = kind;
    r.fields.packet_type    = held_ptype;
    r.fields.data_byte      = data;
    r.fields.byte_pos       = pos[POS_W-1:0];
    r.fields.payload_length = plen[PLEN_W-1:0];
    replies_due.push_back(r);
  endfunction

  // Advance the shadow by one accepted transfer and queue what it must cause.
  function automatic void deframe_step(srd_cmd_t cmd, logic [7:0] b);
    int n;
    int pay;
    if (cmd == CMD_BEGIN) begin
      rx_phase    = PH_HUNT;
      frame_bytes = '0;
      idle_ticks  = '0;
      start2_ok   = 1'b0;
      held_ptype  = '0;
      length_word = '0;
      return;
    end
    if (cmd == CMD_UNUSED || rx_phase == PH_IDLE) return;

    if (cmd == CMD_TICK) begin
      // ticks saturate and accumulate over the whole reply
      if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
      if (idle_ticks >= shadow_timeout) begin
        rx_phase = PH_IDLE;
        expect_reply(KIND_TIMEOUT, '0, 0, 0);
      end
      return;
    end

    if (rx_phase == PH_HUNT) begin
      if (b == shadow_code[15:8]) begin
        rx_phase    = PH_FRAME;
        frame_bytes = 5'd1;
      end
      return;
    end

    frame_bytes = frame_bytes + 5'd1;
    n = int'(frame_bytes);
    if (n == START2_POS) begin
      start2_ok = (b == shadow_code[7:0]);
    end else if (n == TYPE_POS) begin
      held_ptype = b;
    end else if (n == LEN_HI_POS) begin
      length_word = {b, 8'h00};
    end else if (n == HEADER_BYTES) begin
      length_word[7:0] = b;
      if (!start2_ok) begin
        rx_phase = PH_IDLE;
        expect_reply(KIND_BAD, '0, 0, 0);
      end else if (int'(length_word) < CSUM_BYTES ||
                   int'(length_word) - CSUM_BYTES > MAX_PAY) begin
        rx_phase = PH_IDLE;
        expect_reply(KIND_LONG, '0, 0, 0);
      end
    end else if (n > HEADER_BYTES) begin
      pay = int'(length_word) - CSUM_BYTES;
      if (n <= HEADER_BYTES + pay) begin
        expect_reply(KIND_DATA, b, n - HEADER_BYTES - 1, 0);
      end else if (n >= HEADER_BYTES + pay + CSUM_BYTES) begin
        rx_phase = PH_IDLE;
        expect_reply(KIND_DONE, '0, 0, pay);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued transfers, honoring each item's gap and drain hold
  // ---------------------------------------------------------------------------
  link_item_t cur_item;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      // predict at the very edge where the transfer completes
      if (in_tvalid && in_tready) begin
        deframe_step(cur_item.cmd, cur_item.rx);
        items_unaccepted--;
        in_transfers++;
      end
      // hold data stable while the block back-pressures
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (link_queue.size() != 0 &&
                     !(link_queue[0].drain && replies_due.size() != 0)) begin
          cur_item  = link_queue.pop_front();
          gap_left  = cur_item.gap;
          in_tvalid <= 1'b1;
          in_tdata  <= cur_item.rx;
          in_tuser  <= cur_item.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest expectation
  // ---------------------------------------------------------------------------
  srd_result_t seen_reply;
  srd_result_t want_reply;
  int          stall_left = 0;
  bit          rx_calm    = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen_reply.kind   = srd_kind_t'(out_tuser);
        seen_reply.fields = out_tdata[24:0];
        kind_seen[out_tuser]++;
        if (replies_due.size() == 0) begin
          $display("%0t ns: expected none, got kind %0d type %02h data %02h pos %0d len %0d",
                   $realtime, out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[19:16],
                   out_tdata[24:20]);
          mismatches++;
        end else begin
          want_reply = replies_due.pop_front();
          if (seen_reply !== want_reply || out_tdata[31:25] !== '0) begin
            $display("%0t ns: expected kind %0d type %02h data %02h pos %0d len %0d",
                     $realtime, want_reply.kind, want_reply.fields.packet_type,
                     want_reply.fields.data_byte, want_reply.fields.byte_pos,
                     want_reply.fields.payload_length);
            $display("%0t ns: got kind %0d type %02h data %02h pos %0d len %0d pad %02h",
                     $realtime, out_tuser, out_tdata[7:0], out_tdata[15:8],
                     out_tdata[19:16], out_tdata[24:20], out_tdata[31:25]);
            mismatches++;
          end
        end
        // now and then switch between free flow and random stalls
        if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 14);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run stopped after %0d cycles with %0d transfers pending and %0d results due",
             cycle_count, items_unaccepted, replies_due.size());
    $display("sensor_reply_deframer_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(srd_cmd_t cmd, logic [7:0] b, bit tally = 1'b1);
    link_item_t it;
    it.cmd   = cmd;
    it.rx    = b;
    it.gap   = frame_calm ? 0 : $urandom_range(0, 14);
    it.drain = drain_next;
    drain_next = 1'b0;
    link_queue.push_back(it);
    items_unaccepted++;
    if (tally) stim_count++;
  endtask

  // Send one line byte, sometimes preceded by a tick or an unused command.
  task automatic queue_rx(logic [7:0] b);
    if ($urandom_range(0, 9) == 0) queue_item(CMD_TICK, 8'($urandom));
    if ($urandom_range(0, 39) == 0) queue_item(CMD_UNUSED, 8'($urandom));
    queue_item(CMD_BYTE, b);
  endtask

  task automatic queue_header(logic [7:0] hi, logic [7:0] lo, logic [7:0] ptype,
                              logic [15:0] len);
    queue_rx(hi);
    queue_rx(lo);
    repeat (4) queue_rx(8'($urandom));   // address bytes, not checked
    queue_rx(ptype);
    queue_rx(len[15:8]);
    queue_rx(len[7:0]);
  endtask

  // One reply with random content; mostly well formed, sometimes broken.
  task automatic queue_reply(logic [15:0] code, logic [15:0] limit_ticks);
    int          roll;
    int          pay;
    int          body;
    logic [15:0] len;
    logic [7:0]  lo;
    logic [7:0]  junk;
    roll       = $urandom_range(0, 99);
    frame_calm = ($urandom_range(0, 3) == 0);
    queue_item(CMD_BEGIN, 8'($urandom));

    // skip a little line noise ahead of the start byte
    repeat ($urandom_range(0, 2)) begin
      junk = 8'($urandom);
      if (junk == code[15:8]) junk = ~junk;
      queue_rx(junk);
    end

    pay = (roll < 12) ? MAX_PAY : $urandom_range(0, 8);
    len = 16'(pay + CSUM_BYTES);
    if (roll >= 90) begin
      case ($urandom_range(0, 3))
        0:       len = 16'($urandom_range(0, 1));
        1:       len = 16'(MAX_PAY + CSUM_BYTES + $urandom_range(1, 40));
        2:       len = 16'hFFFF;
        default: len = 16'($urandom);
      endcase
    end
    lo = code[7:0];
    if (roll >= 84 && roll < 90) lo = lo ^ (8'h01 << $urandom_range(0, 7));
    queue_header(code[15:8], lo, 8'($urandom), len);

    // body follows only when the header passes
    if (lo == code[7:0] && int'(len) >= CSUM_BYTES && int'(len) - CSUM_BYTES <= MAX_PAY) begin
      body = int'(len);
      if (roll >= 80 && roll < 84) body = $urandom_range(0, body - 1);   // restart mid-frame
      if (roll >= 76 && roll < 80) begin
        // queue ticks part way through; for a timeout of 1 to 64 they run the reply out of time
        if (int'(limit_ticks) <= 64) repeat (limit_ticks) queue_item(CMD_TICK, 8'($urandom));
        else repeat (3) queue_item(CMD_TICK, 8'($urandom));
      end
      repeat (body) queue_rx(8'($urandom));
    end

    // stray bytes, ticks or unused commands; the block drops them when the reply has finished
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2))
        queue_item(srd_cmd_t'($urandom_range(CMD_BYTE, CMD_UNUSED)), 8'($urandom), 1'b0);
    end
  endtask

  task automatic write_reg(srd_cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_START_CODE) shadow_code = val;
    else shadow_timeout = val;
  endtask

  // Wait until every transfer is taken and every result has come back.
  task automatic settle();
    do @(posedge clk);
    while (items_unaccepted != 0 || replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] code;
    logic [15:0] lim;
    int          target;
    int          goal;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset register values: idle input is dropped, a short reply
    // with extreme payload bytes and an unused command inside, then a reply
    // with a wrong second start byte.
    frame_calm = 1'b1;
    queue_item(CMD_BYTE, 8'hEF);
    queue_item(CMD_TICK, 8'h00);
    queue_item(CMD_BEGIN, 8'hFF);
    queue_header(8'hEF, 8'h01, 8'hFF, 16'd4);
    queue_item(CMD_BYTE, 8'h00);
    queue_item(CMD_UNUSED, 8'hFF);
    queue_item(CMD_BYTE, 8'hFF);
    queue_item(CMD_BYTE, 8'hFF);
    queue_item(CMD_BYTE, 8'h00);
    queue_item(CMD_BEGIN, 8'h00);
    queue_header(8'hEF, 8'h00, 8'h00, 16'd2);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          code = 16'h0000; lim = 16'hFFFF; target = 110;
        end
        1: begin
          // zero timeout: the first tick of a reply ends it
          code = 16'hFFFF; lim = 16'h0000; target = 25;
        end
        2: begin
          code = 16'($urandom); lim = 16'($urandom_range(20, 60)); target = 140;
        end
        3: begin
          code = 16'($urandom); lim = 16'd1; target = 25;
        end
        default: begin
          code = START_CODE_RST; lim = TIMEOUT_RST; target = 140;
        end
      endcase
      write_reg(CFG_START_CODE, code);
      write_reg(CFG_TIMEOUT, lim);
      settings_used++;

      goal = stim_count + target;
      for (int f = 0; stim_count < goal; f++) begin
        // every eighth reply waits for the block to empty out first
        drain_next = (f % 8 == 3);
        queue_reply(code, lim);
      end
    end
    settle();

    $display("%0d transfers, %0d register settings, %0d payload bytes, %0d replies complete",
             in_transfers, settings_used, kind_seen[KIND_DATA], kind_seen[KIND_DONE]);
    $display("terminal errors seen: %0d bad start, %0d timeout, %0d too long",
             kind_seen[KIND_BAD], kind_seen[KIND_TIMEOUT], kind_seen[KIND_LONG]);
    if (mismatches == 0) begin
      $display("sensor_reply_deframer_unit test passed");
    end else begin
      $display("sensor_reply_deframer_unit test failed");
    end
    $finish;
  end

endmodule
